>>> rtl/permutation_step_generator_macros.svh
// ----------------------------------------------------------------------------
// permutation step generator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_STEP_GENERATOR_MACROS_SVH
`define PERMUTATION_STEP_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSG_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psg port check failed");

// next-cycle implication, disabled during reset
`define PSG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psg port check failed");

`endif

>>> rtl/psg_pkg.sv
// ----------------------------------------------------------------------------
// psg_pkg
// shared types and constants of the permutation step generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psg_pkg;

   localparam int SYM_W = 8;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD_OTHER,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_DONE
   } psg_state_type;

endpackage

>>> rtl/permutation_step_generator.sv
// ----------------------------------------------------------------------------
// permutation_step_generator
// johnson-trotter stepper: load items build the word, a step item moves the
// largest mobile symbol and streams out the new arrangement
// load item: taken while idle, the input stays ready for the next item
// step item: scan every symbol through the symbol ram read port, read the swap
//   partner and swap, then read and emit each result symbol, waiting on a stalled output
// no mobile symbol: one done result after the scan
// synchronous active-high reset clears the word length and the handshakes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_step_generator
   import psg_pkg::*;
#(
   parameter int MAX_LEN = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_cmd,
   input  logic [SYM_W-1:0] req_symbol_in,
   input  logic             req_first_of_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [SYM_W-1:0] rsp_symbol_out,
   output logic             rsp_last_symbol,
   output logic             rsp_done_res
);

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int CNT_W = $clog2(MAX_LEN + 2);

   psg_state_type    state_ff, state_in;

   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [SYM_W-1:0] w1_ff, w1_in;
   logic [SYM_W-1:0] w2_ff, w2_in;
   logic [SYM_W-1:0] best_val_ff, best_val_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             found_ff, found_in;
   logic [MAX_LEN-1:0] arrow_ff, arrow_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_sym_ff, rsp_sym_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_done_ff, rsp_done_in;

   logic             req_fire;
   logic             slot_free;
   logic [CNT_W-1:0] len_ext;
   logic [CNT_W-1:0] cnt_inc;
   logic [CNT_W-1:0] cnt_m2;
   logic [IDX_W-1:0] eval_idx;
   logic [IDX_W-1:0] other_idx;
   logic             scan_end;
   logic             emit_last;
   logic             load_store;
   logic [IDX_W-1:0] load_addr;
   logic             has_left, has_right, mobile, better;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [SYM_W-1:0] wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [SYM_W-1:0] rd_q;
   logic             rsp_load;
   logic             do_load;
   logic             do_scan;

   psg_sym_ram #(
      .DEPTH (MAX_LEN)
   ) u_sym_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign len_ext   = CNT_W'(len_ff);
   assign cnt_inc   = cnt_ff + CNT_W'(1);
   assign cnt_m2    = cnt_ff - CNT_W'(2);
   assign eval_idx  = cnt_m2[IDX_W-1:0];
   assign scan_end  = (cnt_ff == len_ext + CNT_W'(1));
   assign emit_last = (cnt_inc == len_ext);
   assign other_idx = arrow_ff[best_idx_ff] ? best_idx_ff + IDX_W'(1)
                                            : best_idx_ff - IDX_W'(1);

   assign load_store = req_first_of_word || (len_ff < LEN_W'(MAX_LEN));
   assign load_addr  = req_first_of_word ? '0 : len_ff[IDX_W-1:0];

   // window: w2 left, w1 candidate, rd_q right neighbor
   assign has_left  = (cnt_ff >= CNT_W'(3));
   assign has_right = (cnt_ff <= len_ext);
   assign mobile    = arrow_ff[eval_idx] ? (has_right && (w1_ff > rd_q))
                                         : (has_left  && (w1_ff > w2_ff));
   assign better    = do_scan && (cnt_ff >= CNT_W'(2)) && mobile && (w1_ff > best_val_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_cmd == CMD_STEP)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = found_in ? ST_RD_OTHER : ST_DONE;
            end
         end
         ST_RD_OTHER: state_in = ST_SWAP_A;
         ST_SWAP_A:   state_in = ST_SWAP_B;
         ST_SWAP_B:   state_in = ST_EMIT_RD;
         ST_EMIT_RD:  state_in = ST_EMIT_LD;
         ST_EMIT_LD: begin
            if (slot_free) begin
               state_in = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state decode
   always_comb begin
      req_ready = 1'b0;
      do_load   = 1'b0;
      do_scan   = 1'b0;
      rsp_load  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = load_addr;
      wr_data   = req_symbol_in;
      rd_addr   = cnt_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            do_load   = req_fire && (req_cmd == CMD_LOAD) && load_store;
            wr_en     = do_load;
         end
         ST_SCAN: begin
            do_scan = 1'b1;
         end
         ST_RD_OTHER: begin
            rd_addr = other_idx;
         end
         ST_SWAP_A: begin
            wr_en   = 1'b1;
            wr_addr = best_idx_ff;
            wr_data = rd_q;
         end
         ST_SWAP_B: begin
            wr_en   = 1'b1;
            wr_addr = other_idx;
            wr_data = best_val_ff;
         end
         ST_EMIT_RD: begin
         end
         ST_EMIT_LD: begin
            rsp_load = slot_free;
         end
         ST_DONE: begin
            rsp_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      w1_in       = w1_ff;
      w2_in       = w2_ff;
      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      found_in    = found_ff;
      arrow_in    = arrow_ff;
      rsp_sym_in  = rsp_sym_ff;
      rsp_last_in = rsp_last_ff;
      rsp_done_in = rsp_done_ff;

      if (state_ff == ST_IDLE) begin
         cnt_in      = '0;
         found_in    = 1'b0;
         best_val_in = '0;
      end
      if (do_load) begin
         len_in              = req_first_of_word ? LEN_W'(1) : len_ff + LEN_W'(1);
         arrow_in[load_addr] = 1'b0;
      end
      if (do_scan) begin
         cnt_in = cnt_inc;
         w1_in  = rd_q;
         w2_in  = w1_ff;
      end
      if (better) begin
         found_in    = 1'b1;
         best_val_in = w1_ff;
         best_idx_in = eval_idx;
      end
      // arrows swap together with the last symbol write so other_idx stays put
      if (state_ff == ST_SWAP_B) begin
         arrow_in[best_idx_ff] = arrow_ff[other_idx];
         arrow_in[other_idx]   = arrow_ff[best_idx_ff];
         cnt_in                = '0;
      end
      if (rsp_load) begin
         if (state_ff == ST_DONE) begin
            rsp_sym_in  = '0;
            rsp_last_in = 1'b1;
            rsp_done_in = 1'b1;
         end else begin
            rsp_sym_in  = rd_q;
            rsp_last_in = emit_last;
            rsp_done_in = 1'b0;
            cnt_in      = cnt_inc;
            // symbols larger than the moved one turn around
            if (rd_q > best_val_ff) begin
               arrow_in[cnt_ff[IDX_W-1:0]] = ~arrow_ff[cnt_ff[IDX_W-1:0]];
            end
         end
      end
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      arrow_ff    <= arrow_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol_out  = rsp_sym_ff;
   assign rsp_last_symbol = rsp_last_ff;
   assign rsp_done_res    = rsp_done_ff;

endmodule

>>> rtl/psg_sym_ram.sv
// ----------------------------------------------------------------------------
// psg_sym_ram
// symbol store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psg_sym_ram
   import psg_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [SYM_W-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [SYM_W-1:0]           rd_data
);

   logic [SYM_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/psg_checker.sv
// ----------------------------------------------------------------------------
// psg_checker
// port-level checks of the permutation step generator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "permutation_step_generator_macros.svh"

module psg_checker
   import psg_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_cmd,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [SYM_W-1:0] rsp_symbol_out,
   input logic             rsp_last_symbol,
   input logic             rsp_done_res
);

   // a stalled result item holds
   `PSG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_symbol_out) && $stable(rsp_last_symbol) && $stable(rsp_done_res))

   // done item is a lone zero symbol closing the step
   `PSG_ASSERT_SAME(a_done_form, rsp_valid && rsp_done_res, rsp_last_symbol && (rsp_symbol_out == '0))

   // a step keeps the input side closed while it works
   `PSG_ASSERT_NEXT(a_step_busy, req_valid && req_ready && (req_cmd == CMD_STEP), !req_ready)

   // a load never produces a result item
   `PSG_ASSERT_NEXT(a_load_quiet, req_valid && req_ready && (req_cmd == CMD_LOAD) && !rsp_valid, !rsp_valid)

endmodule

bind permutation_step_generator psg_checker u_psg_checker (.*);
